### src/spi_adc_sample_capture_core_macros.svh
// ----------------------------------------------------------------------------
// SPI ADC sample capture assertion macros
// Concurrent assertion shorthands shared by the capture core.
// ----------------------------------------------------------------------------
`ifndef SPI_ADC_SAMPLE_CAPTURE_CORE_MACROS_SVH
`define SPI_ADC_SAMPLE_CAPTURE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define SASC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sasc assertion failed");
`define SASC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sasc assertion failed");
`else
`define SASC_ASSERT_IMP(label, clk, rst, ante, cons)
`define SASC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

### src/sasc_pkg.sv
// ----------------------------------------------------------------------------
// SPI ADC sample capture package
// Widths, register codes, reset values and shared structures.
// ----------------------------------------------------------------------------
package sasc_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int BIT_COUNT_W = $clog2(SAMPLE_BITS + 1);
   localparam int DATA_W      = 16;
   localparam int INDEX_W     = 8;
   localparam int CLOCK_W     = 32;
   localparam int HALF_W      = 16;
   localparam int CFG_DATA_W  = 32;

   localparam logic [HALF_W-1:0]  HALF_PERIOD_RESET   = 16'd300;
   localparam logic [DATA_W-1:0]  COMMAND_WORD_RESET  = 16'h8000;
   localparam logic [INDEX_W-1:0] FRAME_LENGTH_RESET  = 8'd245;
   localparam logic [CLOCK_W-1:0] TRIGGER_VALUE_RESET = 32'd7;

   typedef enum logic [1:0] {
      CSR_HALF_PERIOD,
      CSR_COMMAND_WORD,
      CSR_FRAME_LENGTH,
      CSR_TRIGGER_VALUE
   } csr_index_type;

   typedef struct packed {
      logic [HALF_W-1:0]  half_period;
      logic [DATA_W-1:0]  command_word;
      logic [INDEX_W-1:0] frame_length;
      logic [CLOCK_W-1:0] trigger_value;
   } cfg_type;

   typedef struct packed {
      logic               chip_select_n;
      logic               serial_clock;
      logic               mosi_level;
      logic               sample_valid;
      logic [DATA_W-1:0]  sample_value;
      logic [INDEX_W-1:0] sample_index;
      logic               frame_last;
   } result_type;

endpackage

### src/sasc_if.sv
// ----------------------------------------------------------------------------
// SPI ADC sample capture channels
// Valid/ready channels for tick words and result words.
// ----------------------------------------------------------------------------
interface sasc_req_if;
   import sasc_pkg::*;

   logic               valid;
   logic               ready;
   logic [CLOCK_W-1:0] clock_word;
   logic               miso;

   modport source (output valid, output clock_word, output miso, input ready);
   modport sink (input valid, input clock_word, input miso, output ready);
endinterface

interface sasc_rsp_if;
   import sasc_pkg::*;

   logic               valid;
   logic               ready;
   logic               chip_select_n;
   logic               serial_clock;
   logic               mosi_level;
   logic               sample_valid;
   logic [DATA_W-1:0]  sample_value;
   logic [INDEX_W-1:0] sample_index;
   logic               frame_last;

   modport source (output valid, output chip_select_n, output serial_clock,
                   output mosi_level, output sample_valid, output sample_value,
                   output sample_index, output frame_last, input ready);
   modport sink (input valid, input chip_select_n, input serial_clock,
                 input mosi_level, input sample_valid, input sample_value,
                 input sample_index, input frame_last, output ready);
endinterface

### src/spi_adc_sample_capture_core.sv
// ----------------------------------------------------------------------------
// SPI ADC sample capture core
// Tick-driven SPI master that converts on a sample clock trigger.
//
// Channel    Direction  Word
// req_chan   in         clock_word, miso: one tick of pin timing
// rsp_chan   out        pin levels and sample fields after that tick
// csr_*      in         register writes: index, data, write enable
//
// One word is accepted per cycle while the result register can take it.
// The result register sits between the sequencer and the result channel.
// A word is accepted while the result register is empty or being emptied.
// Reset is synchronous and returns to idle with chip select high.
// ----------------------------------------------------------------------------
`include "spi_adc_sample_capture_core_macros.svh"

module spi_adc_sample_capture_core (
   input  logic                            clock,
   input  logic                            reset,
   sasc_req_if.sink                        req_chan,
   sasc_rsp_if.source                      rsp_chan,
   input  logic                            csr_write_enable,
   input  sasc_pkg::csr_index_type         csr_index,
   input  logic [sasc_pkg::CFG_DATA_W-1:0] csr_write_data
);
   import sasc_pkg::*;

   cfg_type    cfg_ff;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       accept;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period   <= HALF_PERIOD_RESET;
         cfg_ff.command_word  <= COMMAND_WORD_RESET;
         cfg_ff.frame_length  <= FRAME_LENGTH_RESET;
         cfg_ff.trigger_value <= TRIGGER_VALUE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_HALF_PERIOD:   cfg_ff.half_period   <= csr_write_data[HALF_W-1:0];
            CSR_COMMAND_WORD:  cfg_ff.command_word  <= csr_write_data[DATA_W-1:0];
            CSR_FRAME_LENGTH:  cfg_ff.frame_length  <= csr_write_data[INDEX_W-1:0];
            CSR_TRIGGER_VALUE: cfg_ff.trigger_value <= csr_write_data[CLOCK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   sasc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .advance    (accept),
      .clock_word (req_chan.clock_word),
      .miso       (req_chan.miso),
      .cfg        (cfg_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.chip_select_n = rsp_ff.chip_select_n;
   assign rsp_chan.serial_clock  = rsp_ff.serial_clock;
   assign rsp_chan.mosi_level    = rsp_ff.mosi_level;
   assign rsp_chan.sample_valid  = rsp_ff.sample_valid;
   assign rsp_chan.sample_value  = rsp_ff.sample_value;
   assign rsp_chan.sample_index  = rsp_ff.sample_index;
   assign rsp_chan.frame_last    = rsp_ff.frame_last;

   `SASC_ASSERT_NXT(a_word_gives_result, clock, reset, accept, rsp_chan.valid)
   `SASC_ASSERT_IMP(a_sample_with_cs_high, clock, reset, rsp_chan.valid && rsp_chan.sample_valid, rsp_chan.chip_select_n)
   `SASC_ASSERT_IMP(a_idle_clock_low, clock, reset, rsp_chan.valid && rsp_chan.chip_select_n, !rsp_chan.serial_clock)
   `SASC_ASSERT_IMP(a_no_sample_zero, clock, reset, rsp_chan.valid && !rsp_chan.sample_valid, rsp_chan.sample_value == '0 && rsp_chan.sample_index == '0 && !rsp_chan.frame_last)

endmodule

### src/sasc_engine.sv
// ----------------------------------------------------------------------------
// SPI ADC sample capture engine
// Bit-banged SPI sequencer state, advanced by one tick per accepted word.
// ----------------------------------------------------------------------------
module sasc_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [sasc_pkg::CLOCK_W-1:0] clock_word,
   input  logic                         miso,
   input  sasc_pkg::cfg_type            cfg,
   output sasc_pkg::result_type         result
);
   import sasc_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_START_LOW,
      PH_START_HIGH,
      PH_BIT_LOW,
      PH_BIT_HIGH
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [HALF_W-1:0]      tick_ff, tick_in;
   logic [BIT_COUNT_W-1:0] bit_ff, bit_in, bit_next;
   logic [DATA_W-1:0]      cmd_ff, cmd_in;
   logic [DATA_W-1:0]      data_ff, data_in, data_next;
   logic [INDEX_W-1:0]     frame_ff, frame_in;
   logic                   cs_ff, cs_in;
   logic                   sclk_ff, sclk_in;
   logic                   mosi_ff, mosi_in;
   logic                   done;
   logic                   last;

   assign done      = tick_ff >= cfg.half_period;
   assign bit_next  = bit_ff + BIT_COUNT_W'(1);
   assign data_next = {data_ff[DATA_W-2:0], miso};
   assign last      = ({1'b0, frame_ff} + 9'd1) >= {1'b0, cfg.frame_length};

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      cmd_in   = cmd_ff;
      data_in  = data_ff;
      frame_in = frame_ff;
      cs_in    = cs_ff;
      sclk_in  = sclk_ff;
      mosi_in  = mosi_ff;
      result.sample_valid = 1'b0;
      result.sample_value = '0;
      result.sample_index = '0;
      result.frame_last   = 1'b0;
      case (phase_ff)
         PH_START_LOW, PH_BIT_LOW: begin
            if (done) begin
               sclk_in  = 1'b1;
               phase_in = (phase_ff == PH_START_LOW) ? PH_START_HIGH : PH_BIT_HIGH;
               tick_in  = HALF_W'(1);
            end else begin
               tick_in = tick_ff + HALF_W'(1);
            end
         end
         PH_START_HIGH: begin
            if (done) begin
               sclk_in  = 1'b0;
               mosi_in  = cmd_ff[DATA_W-1];
               cmd_in   = {cmd_ff[DATA_W-2:0], 1'b0};
               bit_in   = '0;
               phase_in = PH_BIT_LOW;
               tick_in  = HALF_W'(1);
            end else begin
               tick_in = tick_ff + HALF_W'(1);
            end
         end
         PH_BIT_HIGH: begin
            if (done) begin
               data_in = data_next;
               tick_in = HALF_W'(1);
               if (bit_next >= BIT_COUNT_W'(SAMPLE_BITS)) begin
                  sclk_in  = 1'b0;
                  cs_in    = 1'b1;
                  result.sample_valid = 1'b1;
                  result.sample_value = data_next;
                  result.sample_index = frame_ff;
                  result.frame_last   = last;
                  frame_in = last ? '0 : frame_ff + INDEX_W'(1);
                  bit_in   = '0;
                  tick_in  = '0;
                  phase_in = PH_IDLE;
               end else begin
                  bit_in   = bit_next;
                  sclk_in  = 1'b0;
                  mosi_in  = cmd_ff[DATA_W-1];
                  cmd_in   = {cmd_ff[DATA_W-2:0], 1'b0};
                  phase_in = PH_BIT_LOW;
               end
            end else begin
               tick_in = tick_ff + HALF_W'(1);
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (clock_word == cfg.trigger_value) begin
               cmd_in   = cfg.command_word;
               data_in  = '0;
               bit_in   = '0;
               cs_in    = 1'b0;
               sclk_in  = 1'b0;
               mosi_in  = 1'b1;
               phase_in = PH_START_LOW;
               tick_in  = HALF_W'(1);
            end
         end
      endcase
      result.chip_select_n = cs_in;
      result.serial_clock  = sclk_in;
      result.mosi_level    = mosi_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         bit_ff   <= '0;
         frame_ff <= '0;
         cs_ff    <= 1'b1;
         sclk_ff  <= 1'b0;
         mosi_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         frame_ff <= frame_in;
         cs_ff    <= cs_in;
         sclk_ff  <= sclk_in;
         mosi_ff  <= mosi_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cmd_ff  <= cmd_in;
         data_ff <= data_in;
      end
   end

endmodule

### tb/sv/spi_adc_sample_capture_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SPI ADC sample capture core testbench
// Feeds tick words through the request channel and predicts every result word
// with a cycle-true model of the SPI sequencer. Registers are rewritten between
// drained phases, and both channels idle at random.
// ----------------------------------------------------------------------------
module spi_adc_sample_capture_core_test;
   import sasc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_TICKS = 1100;
   localparam int REPORT_LIMIT = 20;

   typedef struct packed {
      logic [CLOCK_W-1:0] clock_word;
      logic               miso;
   } tick_type;

   typedef enum logic [2:0] {
      CONV_IDLE,
      CONV_START_LOW,
      CONV_START_HIGH,
      CONV_BIT_LOW,
      CONV_BIT_HIGH
   } conv_phase_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   csr_index_type         csr_index;
   logic [CFG_DATA_W-1:0] csr_write_data;

   sasc_req_if req_chan ();
   sasc_rsp_if rsp_chan ();

   spi_adc_sample_capture_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   tick_type   pending_ticks[$];
   result_type expected_words[$];

   cfg_type                model_cfg;
   conv_phase_type         conv_phase;
   logic [HALF_W-1:0]      phase_ticks;
   logic [BIT_COUNT_W-1:0] bits_done;
   logic [DATA_W-1:0]      command_shift;
   logic [DATA_W-1:0]      capture_shift;
   logic [INDEX_W-1:0]     frame_count;
   logic                   pin_cs_n;
   logic                   pin_sclk;
   logic                   pin_mosi;

   int   ticks_issued;
   int   ticks_accepted;
   int   words_checked;
   int   samples_seen;
   int   frames_closed;
   int   writes_done;
   int   failures;
   int   cycle_count;
   int   send_gap_pct;
   int   recv_stall_pct;
   logic tick_taken;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d words still expected", $time, expected_words.size());
         $display("spi_adc_sample_capture_core_test failed");
         $finish;
      end
   end

   function automatic void shift_out_command();
      pin_sclk      = 1'b0;
      pin_mosi      = command_shift[DATA_W-1];
      command_shift = command_shift << 1;
   endfunction

   task automatic advance_converter(input tick_type t, output result_type r);
      logic last;
      r = '0;
      case (conv_phase)
         CONV_START_LOW, CONV_BIT_LOW: begin
            if (phase_ticks >= model_cfg.half_period) begin
               pin_sclk    = 1'b1;
               conv_phase  = (conv_phase == CONV_START_LOW) ? CONV_START_HIGH : CONV_BIT_HIGH;
               phase_ticks = 16'd1;
            end else begin
               phase_ticks = phase_ticks + 16'd1;
            end
         end
         CONV_START_HIGH: begin
            if (phase_ticks >= model_cfg.half_period) begin
               shift_out_command();
               bits_done   = '0;
               conv_phase  = CONV_BIT_LOW;
               phase_ticks = 16'd1;
            end else begin
               phase_ticks = phase_ticks + 16'd1;
            end
         end
         CONV_BIT_HIGH: begin
            if (phase_ticks >= model_cfg.half_period) begin
               capture_shift = {capture_shift[DATA_W-2:0], t.miso};
               bits_done     = bits_done + BIT_COUNT_W'(1);
               phase_ticks   = 16'd1;
               if (bits_done >= SAMPLE_BITS) begin
                  last           = ({1'b0, frame_count} + 9'd1) >= {1'b0, model_cfg.frame_length};
                  pin_sclk       = 1'b0;
                  pin_cs_n       = 1'b1;
                  r.sample_valid = 1'b1;
                  r.sample_value = capture_shift;
                  r.sample_index = frame_count;
                  r.frame_last   = last;
                  frame_count    = last ? '0 : frame_count + 8'd1;
                  bits_done      = '0;
                  phase_ticks    = '0;
                  conv_phase     = CONV_IDLE;
               end else begin
                  shift_out_command();
                  conv_phase = CONV_BIT_LOW;
               end
            end else begin
               phase_ticks = phase_ticks + 16'd1;
            end
         end
         default: begin
            conv_phase = CONV_IDLE;
            if (t.clock_word == model_cfg.trigger_value) begin
               command_shift = model_cfg.command_word;
               capture_shift = '0;
               bits_done     = '0;
               pin_cs_n      = 1'b0;
               pin_sclk      = 1'b0;
               pin_mosi      = 1'b1;
               conv_phase    = CONV_START_LOW;
               phase_ticks   = 16'd1;
            end
         end
      endcase
      r.chip_select_n = pin_cs_n;
      r.serial_clock  = pin_sclk;
      r.mosi_level    = pin_mosi;
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         failures++;
         if (failures <= REPORT_LIMIT) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
         end
      end
   endtask

   // Result words are checked before the tick accepted at the same edge is predicted.
   always @(posedge clock) begin
      result_type want;
      result_type got;
      tick_type   t;
      if (reset) begin
         tick_taken <= 1'b0;
      end else begin
         tick_taken <= req_chan.valid && req_chan.ready;
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.chip_select_n = rsp_chan.chip_select_n;
            got.serial_clock  = rsp_chan.serial_clock;
            got.mosi_level    = rsp_chan.mosi_level;
            got.sample_valid  = rsp_chan.sample_valid;
            got.sample_value  = rsp_chan.sample_value;
            got.sample_index  = rsp_chan.sample_index;
            got.frame_last    = rsp_chan.frame_last;
            if (expected_words.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT) begin
                  $display("%0t: unexpected word, expected none, actual 0x%0h", $time, got);
               end
            end else begin
               want = expected_words.pop_front();
               compare_field("chip_select_n", 32'(want.chip_select_n),
                             32'(got.chip_select_n));
               compare_field("serial_clock", 32'(want.serial_clock), 32'(got.serial_clock));
               compare_field("mosi_level", 32'(want.mosi_level), 32'(got.mosi_level));
               compare_field("sample_valid", 32'(want.sample_valid), 32'(got.sample_valid));
               compare_field("sample_value", 32'(want.sample_value), 32'(got.sample_value));
               compare_field("sample_index", 32'(want.sample_index), 32'(got.sample_index));
               compare_field("frame_last", 32'(want.frame_last), 32'(got.frame_last));
               if (want.sample_valid) samples_seen++;
               if (want.sample_valid && want.frame_last) frames_closed++;
            end
            words_checked++;
         end
         if (req_chan.valid && req_chan.ready) begin
            t.clock_word = req_chan.clock_word;
            t.miso       = req_chan.miso;
            advance_converter(t, want);
            expected_words.push_back(want);
            ticks_accepted++;
         end
      end
   end

   always @(negedge clock) begin
      tick_type t;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || tick_taken) begin
         if (pending_ticks.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
            t = pending_ticks.pop_front();
            req_chan.valid      <= 1'b1;
            req_chan.clock_word <= t.clock_word;
            req_chan.miso       <= t.miso;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic queue_tick(input logic [CLOCK_W-1:0] word, input logic miso_bit);
      tick_type t;
      t.clock_word = word;
      t.miso       = miso_bit;
      pending_ticks.push_back(t);
      ticks_issued++;
   endtask

   task automatic queue_burst(input int count, input int trigger_pct);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < trigger_pct) begin
            queue_tick(model_cfg.trigger_value, 1'($urandom_range(1)));
         end else begin
            queue_tick($urandom, 1'($urandom_range(1)));
         end
      end
   endtask

   task automatic wait_for_drain();
      while (ticks_accepted != ticks_issued || expected_words.size() != 0) begin
         @(negedge clock);
      end
      repeat (2) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CFG_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         CSR_HALF_PERIOD:  model_cfg.half_period   = data[HALF_W-1:0];
         CSR_COMMAND_WORD: model_cfg.command_word  = data[DATA_W-1:0];
         CSR_FRAME_LENGTH: model_cfg.frame_length  = data[INDEX_W-1:0];
         default:          model_cfg.trigger_value = data[CLOCK_W-1:0];
      endcase
      writes_done++;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int random_ticks;
      int count;
      int span;
      int pct;
      int stage;
      reset               = 1'b1;
      csr_write_enable    = 1'b0;
      csr_index           = CSR_HALF_PERIOD;
      csr_write_data      = '0;
      req_chan.valid      = 1'b0;
      req_chan.clock_word = '0;
      req_chan.miso       = 1'b0;
      rsp_chan.ready      = 1'b0;
      tick_taken          = 1'b0;
      cycle_count         = 0;
      ticks_issued        = 0;
      ticks_accepted      = 0;
      words_checked       = 0;
      samples_seen        = 0;
      frames_closed       = 0;
      writes_done         = 0;
      failures            = 0;
      random_ticks        = 0;
      send_gap_pct        = 9;
      recv_stall_pct      = 71;
      model_cfg.half_period   = HALF_PERIOD_RESET;
      model_cfg.command_word  = COMMAND_WORD_RESET;
      model_cfg.frame_length  = FRAME_LENGTH_RESET;
      model_cfg.trigger_value = TRIGGER_VALUE_RESET;
      conv_phase    = CONV_IDLE;
      phase_ticks   = '0;
      bits_done     = '0;
      command_shift = '0;
      capture_shift = '0;
      frame_count   = '0;
      pin_cs_n      = 1'b1;
      pin_sclk      = 1'b0;
      pin_mosi      = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: words around the trigger, then a conversion at the long period.
      queue_tick('0, 1'b0);
      queue_tick('1, 1'b1);
      queue_tick(TRIGGER_VALUE_RESET - 1, 1'b1);
      queue_tick(TRIGGER_VALUE_RESET, 1'b1);
      queue_burst(6, 0);
      wait_for_drain();

      // A zero half period and zero frame length, written mid-conversion.
      write_register(CSR_HALF_PERIOD, 32'd0);
      write_register(CSR_COMMAND_WORD, 32'h0000_FFFF);
      write_register(CSR_FRAME_LENGTH, 32'd0);
      write_register(CSR_TRIGGER_VALUE, 32'd0);
      queue_burst(40, 0);
      queue_burst(75, 100);
      wait_for_drain();

      // Back-to-back conversions with the trigger held.
      write_register(CSR_TRIGGER_VALUE, 32'hFFFF_FFFF);
      write_register(CSR_COMMAND_WORD, 32'd0);
      write_register(CSR_FRAME_LENGTH, 32'd255);
      write_register(CSR_HALF_PERIOD, 32'd1);
      queue_burst(110, 100);
      wait_for_drain();

      // The frame shrinks below the current count while a long phase stalls.
      write_register(CSR_FRAME_LENGTH, 32'd2);
      write_register(CSR_HALF_PERIOD, 32'h0000_FFFF);
      queue_burst(60, 100);
      wait_for_drain();
      write_register(CSR_HALF_PERIOD, 32'd2);
      queue_burst(80, 0);

      while (random_ticks < RANDOM_TICKS) begin
         wait_for_drain();
         stage = random_ticks * 3 / RANDOM_TICKS;
         send_gap_pct   = (stage == 0) ? 9 : (stage == 1) ? 71 : 0;
         recv_stall_pct = (stage == 0) ? 71 : (stage == 1) ? 9 : 0;
         if ($urandom_range(9) < 6) begin
            case ($urandom_range(9))
               0:       write_register(CSR_HALF_PERIOD, 32'd0);
               6, 7:    write_register(CSR_HALF_PERIOD, 32'd2);
               8:       write_register(CSR_HALF_PERIOD, 32'd3);
               9:       write_register(CSR_HALF_PERIOD, $urandom_range(6, 4));
               default: write_register(CSR_HALF_PERIOD, 32'd1);
            endcase
         end
         if ($urandom_range(9) < 6) begin
            case ($urandom_range(5))
               0:       write_register(CSR_COMMAND_WORD, 32'd0);
               1:       write_register(CSR_COMMAND_WORD, 32'h0000_FFFF);
               default: write_register(CSR_COMMAND_WORD, $urandom_range(16'hFFFF));
            endcase
         end
         if ($urandom_range(9) < 6) begin
            case ($urandom_range(7))
               0:       write_register(CSR_FRAME_LENGTH, 32'd0);
               1:       write_register(CSR_FRAME_LENGTH, 32'd1);
               2:       write_register(CSR_FRAME_LENGTH, $urandom_range(4, 2));
               3:       write_register(CSR_FRAME_LENGTH, 32'd255);
               default: write_register(CSR_FRAME_LENGTH, $urandom_range(8, 1));
            endcase
         end
         if ($urandom_range(9) < 6) begin
            case ($urandom_range(4))
               0:       write_register(CSR_TRIGGER_VALUE, 32'd0);
               1:       write_register(CSR_TRIGGER_VALUE, 32'hFFFF_FFFF);
               default: write_register(CSR_TRIGGER_VALUE, $urandom);
            endcase
         end
         span = (model_cfg.half_period == 0) ? 1 :
                (model_cfg.half_period > 6) ? 6 : int'(model_cfg.half_period);
         span = 34 * span + 2;
         count = span * $urandom_range(3, 1) + $urandom_range(20);
         case ($urandom_range(9))
            0:       pct = 100;
            1, 2:    pct = 5;
            default: pct = 35;
         endcase
         queue_burst(count, pct);
         random_ticks += count;
      end

      wait_for_drain();
      repeat (4) @(negedge clock);
      if (expected_words.size() != 0) begin
         failures++;
         $display("%0t: %0d expected words never arrived", $time, expected_words.size());
      end
      $display("Checked %0d result words for %0d tick words after %0d register writes.",
               words_checked, ticks_accepted, writes_done);
      $display("The run captured %0d samples, %0d of them closing a frame.",
               samples_seen, frames_closed);
      if (failures == 0) begin
         $display("spi_adc_sample_capture_core_test passed");
      end else begin
         $display("spi_adc_sample_capture_core_test failed");
      end
      $finish;
   end
endmodule
